FILE: design/double_hash_displacing_table_defines.svh
// Assertion macros for the double hashing displacement table.
// Used by the top level only; needs clock and reset in scope.
`ifndef DOUBLE_HASH_DISPLACING_TABLE_DEFINES_SVH
`define DOUBLE_HASH_DISPLACING_TABLE_DEFINES_SVH
// same-cycle implication
`define DHDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dhdt assertion failed");
// next-cycle implication
`define DHDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dhdt assertion failed");
`endif

FILE: design/dhdt_pkg.sv
// Shared types and constants of the double hashing displacement table.
// No dependencies.
`timescale 1ns / 1ps
package dhdt_pkg;
   localparam int MAX_SLOTS = 1024;
   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = 11;
   localparam int KEY_W = 64;
   localparam int HASH_W = 31;
   localparam int VAL_W = 32;
   localparam int CM1_W = 32;
   localparam int PROD_W = CM1_W + CNT_W;
   localparam int DIV_W = PROD_W + 1;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_REPLACED = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MS_HOME = 2'd0,
      MS_INC  = 2'd1,
      MS_IDX  = 2'd2
   } mod_sel_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      logic [VAL_W-1:0]  value;
      logic [CNT_W-1:0]  probes;
   } entry_type;

   typedef struct packed {
      logic        clr_wr;
      logic        load;
      logic        mod_start;
      mod_sel_type mod_sel;
      logic        cap_home;
      logic        cap_inc;
      logic        cap_idx;
      logic        rd;
      logic        adv;
      logic        wr_cur;
      logic        swap;
      logic        occ_inc;
      logic        rsp_load;
      status_type  rsp_code;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic mod_done;
      logic func;
      logic top;
      logic e_valid;
      logic e_match;
      logic e_stop;
      logic full;
      logic steps_lim;
   } stat_type;
endpackage

FILE: design/double_hash_displacing_table.sv
// Top level of the double hashing displacement table.
// Depends on dhdt_pkg, dhdt_ctrl, dhdt_datapath and the defines header.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  func, key, hash_value, value
//  rsp      out        rsp_valid/rsp_ready  status, value_out, occupancy_out
//  csr      in         csr_valid/csr_ready  table_size
//
// One request at a time. Each walk start runs three serial remainder passes
// (home, step, index); each probe reads memory in S_RD, then compares in S_EVAL.
// A displacement restarts the walk for the bumped entry.
// After reset a clearing pass writes all 1024 slots before req_ready rises.
// csr is always ready; rsp holds until taken, then req_ready returns.
`timescale 1ns / 1ps
`include "double_hash_displacing_table_defines.svh"
module double_hash_displacing_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [63:0] req_key,
   input  logic [30:0] req_hash_value,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [10:0] rsp_occupancy_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_table_size
);
   dhdt_pkg::cmd_type  cmd;
   dhdt_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   dhdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   dhdt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write         (csr_valid && csr_ready),
      .csr_table_size    (csr_table_size),
      .req_func          (req_func),
      .req_key           (req_key),
      .req_hash_value    (req_hash_value),
      .req_value         (req_value),
      .rsp_status        (rsp_status),
      .rsp_value_out     (rsp_value_out),
      .rsp_occupancy_out (rsp_occupancy_out)
   );

   `DHDT_ASSERT_NOW(a_one_at_a_time, rsp_valid, !req_ready)
   `DHDT_ASSERT_NEXT(a_back_to_idle, rsp_valid && rsp_ready, req_ready)
   `DHDT_ASSERT_NOW(a_occ_bound, rsp_valid,
      rsp_occupancy_out <= 11'(dhdt_pkg::MAX_SLOTS))
   `DHDT_ASSERT_NOW(a_no_write_on_lookup, stat.func && !req_ready, !cmd.wr_cur)
endmodule

FILE: design/dhdt_mod.sv
// Bit-serial remainder unit, one dividend bit per cycle.
// Depends on dhdt_pkg.
`timescale 1ns / 1ps
module dhdt_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dhdt_pkg::DIV_W-1:0]  dividend,
   input  logic [dhdt_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic [dhdt_pkg::CNT_W-1:0]  remainder
);
   logic [dhdt_pkg::DIV_W-1:0]  num_ff;
   logic [dhdt_pkg::CNT_W-1:0]  den_ff;
   logic [dhdt_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [dhdt_pkg::DCNT_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff;
   logic [dhdt_pkg::CNT_W:0]    trial;

   always_comb begin
      trial = {rem_ff, num_ff[dhdt_pkg::DIV_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         trial = trial - {1'b0, den_ff};
      end
      rem_in = trial[dhdt_pkg::CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[dhdt_pkg::DIV_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == dhdt_pkg::DCNT_W'(dhdt_pkg::DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff;
endmodule

FILE: design/dhdt_datapath.sv
// Datapath: slot memory, carried entry, probe index arithmetic, outputs.
// Depends on dhdt_pkg and dhdt_mod.
`timescale 1ns / 1ps
module dhdt_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  dhdt_pkg::cmd_type            cmd,
   output dhdt_pkg::stat_type           stat,
   input  logic                         csr_write,
   input  logic [10:0]                  csr_table_size,
   input  logic                         req_func,
   input  logic [63:0]                  req_key,
   input  logic [30:0]                  req_hash_value,
   input  logic [31:0]                  req_value,
   output logic [2:0]                   rsp_status,
   output logic [31:0]                  rsp_value_out,
   output logic [10:0]                  rsp_occupancy_out
);
   dhdt_pkg::entry_type mem [dhdt_pkg::MAX_SLOTS];
   dhdt_pkg::entry_type rd_q, wr_entry;

   logic [10:0]                  size_ff, size;
   logic                         func_ff, top_ff;
   logic [dhdt_pkg::KEY_W-1:0]   k_ff;
   logic [dhdt_pkg::HASH_W-1:0]  h_ff;
   logic [dhdt_pkg::VAL_W-1:0]   v_ff;
   logic [dhdt_pkg::CNT_W-1:0]   c_ff, steps_ff, occ_ff, inc_ff;
   logic [dhdt_pkg::IDX_W-1:0]   home_ff, idx_ff, clr_ptr_ff;
   logic [2:0]                   status_ff;
   logic [dhdt_pkg::VAL_W-1:0]   vout_ff;
   logic [dhdt_pkg::CM1_W-1:0]   cm1;
   logic [dhdt_pkg::PROD_W-1:0]  prod;
   logic [dhdt_pkg::DIV_W-1:0]   mod_num;
   logic [dhdt_pkg::CNT_W-1:0]   mod_den, mod_rem, idx_sum;
   logic                         mod_done;

   always_comb begin
      size = size_ff;
      if (size_ff < 11'd3) size = 11'd3;
      if (size_ff > 11'(dhdt_pkg::MAX_SLOTS)) size = 11'(dhdt_pkg::MAX_SLOTS);
   end

   assign cm1 = (c_ff == '0) ? '1 : dhdt_pkg::CM1_W'(c_ff - 1'b1);
   assign prod = dhdt_pkg::PROD_W'(cm1) * dhdt_pkg::PROD_W'(inc_ff);

   always_comb begin
      mod_den = size;
      mod_num = dhdt_pkg::DIV_W'(h_ff);
      case (cmd.mod_sel)
         dhdt_pkg::MS_HOME: mod_num = dhdt_pkg::DIV_W'(h_ff);
         dhdt_pkg::MS_INC: begin
            mod_den = size - 1'b1;
         end
         dhdt_pkg::MS_IDX: mod_num = dhdt_pkg::DIV_W'(prod) + dhdt_pkg::DIV_W'(home_ff);
         default: mod_num = dhdt_pkg::DIV_W'(h_ff);
      endcase
   end

   dhdt_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_num),
      .divisor   (mod_den),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      idx_sum = dhdt_pkg::CNT_W'(idx_ff) + inc_ff;
      if (idx_sum >= size) idx_sum = idx_sum - size;
   end

   assign wr_entry = '{valid: 1'b1, key: k_ff, hash: h_ff, value: v_ff, probes: c_ff};

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_ptr_ff] <= '0;
      end else if (cmd.wr_cur) begin
         mem[idx_ff] <= wr_entry;
      end
      if (cmd.rd) begin
         rd_q <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= 11'd1021;
         occ_ff     <= '0;
         clr_ptr_ff <= '0;
         c_ff       <= 11'd1;
      end else begin
         if (csr_write) size_ff <= csr_table_size;
         if (cmd.clr_wr) clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (cmd.occ_inc) occ_ff <= occ_ff + 1'b1;
         if (cmd.load) begin
            c_ff <= 11'd1;
         end else if (cmd.swap) begin
            c_ff <= rd_q.probes + 1'b1;
         end else if (cmd.adv) begin
            c_ff <= c_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         k_ff     <= req_key;
         h_ff     <= req_hash_value;
         v_ff     <= req_value;
         steps_ff <= '0;
         top_ff   <= 1'b1;
      end else if (cmd.swap) begin
         k_ff     <= rd_q.key;
         h_ff     <= rd_q.hash;
         v_ff     <= rd_q.value;
         steps_ff <= steps_ff + 1'b1;
         top_ff   <= 1'b0;
      end
      if (cmd.cap_home) home_ff <= mod_rem[dhdt_pkg::IDX_W-1:0];
      if (cmd.cap_inc) inc_ff <= mod_rem + 1'b1;
      if (cmd.cap_idx) begin
         idx_ff <= mod_rem[dhdt_pkg::IDX_W-1:0];
      end else if (cmd.adv) begin
         idx_ff <= idx_sum[dhdt_pkg::IDX_W-1:0];
      end
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_code;
         vout_ff   <= (cmd.rsp_code == dhdt_pkg::ST_FOUND) ? rd_q.value : '0;
      end
   end

   always_comb begin
      stat.clr_done  = (clr_ptr_ff == dhdt_pkg::IDX_W'(dhdt_pkg::MAX_SLOTS - 1));
      stat.mod_done  = mod_done;
      stat.func      = func_ff;
      stat.top       = top_ff;
      stat.e_valid   = rd_q.valid;
      stat.e_match   = rd_q.valid && (rd_q.key == k_ff);
      stat.e_stop    = (rd_q.probes < c_ff) || (c_ff > size);
      stat.full      = (occ_ff >= size);
      stat.steps_lim = (steps_ff >= size);
   end

   assign rsp_status = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_occupancy_out = occ_ff;
endmodule

FILE: design/dhdt_ctrl.sv
// Controller: clearing pass, probe walk sequencing, displacement decisions.
// Depends on dhdt_pkg.
`timescale 1ns / 1ps
module dhdt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  dhdt_pkg::stat_type  stat,
   output dhdt_pkg::cmd_type   cmd,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_H_GO, S_H_WAIT, S_I_GO, S_I_WAIT,
      S_X_GO, S_X_WAIT, S_RD, S_EVAL, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      cmd.mod_sel = dhdt_pkg::MS_HOME;
      cmd.rsp_code = dhdt_pkg::ST_NOTFOUND;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_H_GO;
            end
         end
         S_H_GO: begin
            cmd.mod_start = 1'b1;
            state_in = S_H_WAIT;
         end
         S_H_WAIT: begin
            if (stat.mod_done) begin
               cmd.cap_home = 1'b1;
               state_in = S_I_GO;
            end
         end
         S_I_GO: begin
            cmd.mod_sel = dhdt_pkg::MS_INC;
            cmd.mod_start = 1'b1;
            state_in = S_I_WAIT;
         end
         S_I_WAIT: begin
            if (stat.mod_done) begin
               cmd.cap_inc = 1'b1;
               state_in = S_X_GO;
            end
         end
         S_X_GO: begin
            cmd.mod_sel = dhdt_pkg::MS_IDX;
            cmd.mod_start = 1'b1;
            state_in = S_X_WAIT;
         end
         S_X_WAIT: begin
            if (stat.mod_done) begin
               cmd.cap_idx = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.func) begin
               if (stat.e_match) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_code = dhdt_pkg::ST_FOUND;
                  state_in = S_RESP;
               end else if (!stat.e_valid || stat.e_stop) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_code = dhdt_pkg::ST_NOTFOUND;
                  state_in = S_RESP;
               end else begin
                  cmd.adv = 1'b1;
                  state_in = S_RD;
               end
            end else begin
               if (stat.e_match) begin
                  cmd.wr_cur = 1'b1;
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_code = stat.top ? dhdt_pkg::ST_REPLACED : dhdt_pkg::ST_INSERTED;
                  state_in = S_RESP;
               end else if (!stat.e_valid || stat.e_stop) begin
                  cmd.rsp_load = 1'b1;
                  state_in = S_RESP;
                  if (stat.top && stat.full) begin
                     cmd.rsp_code = dhdt_pkg::ST_FULL;
                  end else if (!stat.e_valid) begin
                     cmd.wr_cur = 1'b1;
                     cmd.occ_inc = 1'b1;
                     cmd.rsp_code = dhdt_pkg::ST_INSERTED;
                  end else if (stat.steps_lim) begin
                     cmd.rsp_code = dhdt_pkg::ST_INSERTED;
                  end else begin
                     cmd.rsp_load = 1'b0;
                     cmd.wr_cur = 1'b1;
                     cmd.swap = 1'b1;
                     state_in = S_H_GO;
                  end
               end else begin
                  cmd.adv = 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
endmodule

FILE: bench/testbench.sv
// Self-checking testbench for double_hash_displacing_table.
// Holds a table predictor in a scoreboard class; depends on dhdt_pkg and the RTL only.
`timescale 1ns / 1ps
module testbench;
   localparam int IDLE_LIMIT = 8000000;
   localparam int HOLD_CYCLES = 3000;
   localparam int KEY_POOL = 256;

   typedef struct {
      dhdt_pkg::status_type status;
      logic [31:0]          value_out;
      logic [10:0]          occupancy;
   } outcome_type;

   class table_scoreboard;
      bit                valid[dhdt_pkg::MAX_SLOTS];
      logic [63:0]       keys[dhdt_pkg::MAX_SLOTS];
      int unsigned       hashes[dhdt_pkg::MAX_SLOTS];
      logic [31:0]       values[dhdt_pkg::MAX_SLOTS];
      int unsigned       probes[dhdt_pkg::MAX_SLOTS];
      int unsigned       size_reg;
      int unsigned       occupied;
      int                errors;
      outcome_type       expected_q[$];

      function new();
         size_reg = 1021;
         occupied = 0;
         errors = 0;
         foreach (valid[i]) valid[i] = 0;
      endfunction

      function void set_size(logic [10:0] v);
         size_reg = 32'(v);
      endfunction

      function int unsigned slots_in_use();
         if (size_reg < 3) return 3;
         if (size_reg > dhdt_pkg::MAX_SLOTS) return dhdt_pkg::MAX_SLOTS;
         return size_reg;
      endfunction

      function bit walk(logic [63:0] k, int unsigned h, int unsigned sz,
                        inout int unsigned c, output int unsigned slot);
         longint unsigned home, step, idx;
         home = 64'(h % sz);
         step = 64'(h % (sz - 1) + 1);
         idx = (home + longint'(c - 1) * step) % sz;
         forever begin
            slot = 32'(idx);
            if (!valid[slot]) return 0;
            if (keys[slot] == k) return 1;
            if (probes[slot] < c || c > sz) return 0;
            idx = (idx + step) % sz;
            c++;
         end
      endfunction

      function void place(int unsigned i, logic [63:0] k, int unsigned h,
                          logic [31:0] v, int unsigned c);
         valid[i] = 1;
         keys[i] = k;
         hashes[i] = h;
         values[i] = v;
         probes[i] = c & 11'h7ff;
      endfunction

      function dhdt_pkg::status_type insert(logic [63:0] key, int unsigned h,
                                            logic [31:0] v, int unsigned sz);
         logic [63:0] k, rk;
         logic [31:0] rv;
         int unsigned carried, c, slot, steps, rh, rc;
         bit top;
         k = key;
         carried = 1;
         steps = 0;
         top = 1;
         forever begin
            c = carried;
            if (walk(k, h, sz, c, slot)) begin
               place(slot, k, h, v, c);
               return top ? dhdt_pkg::ST_REPLACED : dhdt_pkg::ST_INSERTED;
            end
            if (top && occupied >= sz) return dhdt_pkg::ST_FULL;
            if (!valid[slot]) begin
               place(slot, k, h, v, c);
               occupied++;
               return dhdt_pkg::ST_INSERTED;
            end
            if (steps >= sz) return dhdt_pkg::ST_INSERTED;
            rk = keys[slot];
            rh = hashes[slot];
            rv = values[slot];
            rc = probes[slot];
            place(slot, k, h, v, c);
            k = rk;
            h = rh;
            v = rv;
            carried = (rc + 1) & 11'h7ff;
            steps++;
            top = 0;
         end
      endfunction

      function void note_request(logic func, logic [63:0] key, logic [30:0] h,
                                 logic [31:0] v);
         outcome_type o;
         int unsigned sz, c, slot;
         sz = slots_in_use();
         o.value_out = '0;
         if (func == 1'b0) begin
            o.status = insert(key, 32'(h), v, sz);
         end else begin
            c = 1;
            if (walk(key, 32'(h), sz, c, slot)) begin
               o.status = dhdt_pkg::ST_FOUND;
               o.value_out = values[slot];
            end else begin
               o.status = dhdt_pkg::ST_NOTFOUND;
            end
         end
         o.occupancy = 11'(occupied);
         expected_q.push_back(o);
      endfunction

      function void check_response(logic [2:0] st, logic [31:0] vo, logic [10:0] occ);
         outcome_type o;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            errors++;
            return;
         end
         o = expected_q.pop_front();
         if (st !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, st);
            errors++;
         end
         if (vo !== o.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, o.value_out, vo);
            errors++;
         end
         if (occ !== o.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, o.occupancy, occ);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [63:0] req_key;
   logic [30:0] req_hash_value;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [10:0] rsp_occupancy_out;
   logic        csr_valid;
   logic        csr_ready;
   logic [10:0] csr_table_size;

   table_scoreboard sb;
   bit          no_idle;
   bit          hold_pending;
   logic [63:0] pool_key[KEY_POOL];
   logic [30:0] pool_hash[KEY_POOL];

   double_hash_displacing_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_key(req_key), .req_hash_value(req_hash_value), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out), .rsp_occupancy_out(rsp_occupancy_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_table_size(csr_table_size)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_value_out, rsp_occupancy_out);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 0;
         end else if (hold_pending) begin
            hold_pending = 0;
            stall_left = HOLD_CYCLES;
            rsp_ready <= 0;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send(logic func, logic [63:0] key, logic [30:0] h, logic [31:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_key <= key;
      req_hash_value <= h;
      req_value <= v;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(func, key, h, v);
   endtask

   task automatic write_size(logic [10:0] v);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_table_size <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.set_size(v);
      csr_valid <= 0;
   endtask

   task automatic random_phase(logic [10:0] sz, int count);
      int unsigned pool_n, eff, p;
      logic [63:0] k;
      logic [30:0] h;
      eff = (sz < 3) ? 3 : (sz > dhdt_pkg::MAX_SLOTS) ? dhdt_pkg::MAX_SLOTS : 32'(sz);
      pool_n = (2 * eff + 2 < KEY_POOL) ? 2 * eff + 2 : KEY_POOL;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(0, pool_n - 1);
         k = pool_key[p];
         h = pool_hash[p];
         if ($urandom_range(0, 99) < 8) k = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 5) h = 31'($urandom);
         send($urandom_range(0, 99) < 45, k, h, $urandom);
      end
   endtask

   initial begin : stimulus
      logic [10:0] sizes[12];
      sb = new();
      req_valid = 0;
      req_func = 0;
      req_key = '0;
      req_hash_value = '0;
      req_value = '0;
      csr_valid = 0;
      csr_table_size = '0;
      no_idle = 0;
      hold_pending = 0;
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_key[i] = {$urandom, $urandom};
         pool_hash[i] = 31'($urandom);
      end
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: field extremes at reset size
      send(0, 64'h0, 31'h0, 32'hffffffff);
      send(0, '1, 31'h7fffffff, 32'h0);
      send(1, 64'h0, 31'h0, 32'h0);
      send(1, '1, 31'h7fffffff, 32'h0);
      send(1, 64'h5, 31'h0, 32'h0);
      send(0, 64'h0, 31'h0, 32'h12345678);
      send(0, 64'h7, 31'd1021, 32'h1);
      send(1, 64'h7, 31'd1021, 32'h0);
      // smallest table: fill, refuse, replace when full, miss on full table
      write_size(11'd3);
      send(0, 64'h10, 31'd0, 32'ha);
      send(0, 64'h11, 31'd0, 32'hb);
      send(0, 64'h12, 31'd3, 32'hc);
      send(0, 64'h13, 31'd6, 32'hd);
      send(0, 64'h11, 31'd0, 32'he);
      send(1, 64'h11, 31'd0, 32'h0);
      send(1, 64'h99, 31'd0, 32'h0);
      // size below range saturates; entries outside kept
      write_size(11'd0);
      send(1, 64'h12, 31'd3, 32'h0);
      // non-prime size, same-step collisions force displacement chains
      write_size(11'd4);
      for (int i = 0; i < 6; i++) send(0, 64'h20 + i, 31'(2 * i), 32'(i));
      write_size(11'h7ff);
      send(1, 64'h0, 31'h0, 32'h0);

      sizes = '{11'd5, 11'd8, 11'd13, 11'd2, 11'd16, 11'd61,
                11'd1021, 11'd4, 11'd1024, 11'd97, 11'h7ff, 11'd3};
      foreach (sizes[i]) begin
         write_size(sizes[i]);
         no_idle = (i == 3);
         if (i == 1) hold_pending = 1;
         random_phase(sizes[i], 118);
      end
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
